// ----- rtl/sfet_pkg.sv -----
// shared types and constants for the sensor frame event trigger
// used by the channel interfaces and the top level
package sfet_pkg;

	localparam int unsigned ByteW    = 8;
	localparam int unsigned SetW     = 32;
	localparam int unsigned MidW     = 10;
	localparam int unsigned ThrW     = 32;
	localparam int unsigned PosW     = 30;
	localparam int unsigned ErrW     = 33;
	localparam int unsigned CfgDataW = 32;
	localparam int unsigned WinDepth = 3;
	localparam int unsigned FillW    = 2;

	localparam logic [ByteW-1:0] StartByte = 8'hFF;
	localparam logic signed [PosW-1:0] PosCoef = 30'sd4260;

	typedef enum logic [1:0] {
		ST_GOOD      = 2'd0,
		ST_BAD_START = 2'd1,
		ST_BAD_SUM   = 2'd2
	} status_t;

	typedef enum logic {
		REG_MIDDLE = 1'b0,
		REG_THRESH = 1'b1
	} cfg_reg_t;

endpackage

// ----- rtl/sfet_in_if.sv -----
// input channel of the sensor frame event trigger: one received byte per item
// depends on sfet_pkg
interface sfet_in_if;
	import sfet_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [ByteW-1:0]       rx_byte;
	logic signed [SetW-1:0] setpoint;
	logic                   event_taken;

	modport source (output valid, output rx_byte, output setpoint, output event_taken,
		input ready);
	modport sink (input valid, input rx_byte, input setpoint, input event_taken,
		output ready);
endinterface

// ----- rtl/sfet_out_if.sv -----
// result channel of the sensor frame event trigger: one checked frame per item
// depends on sfet_pkg
interface sfet_out_if;
	import sfet_pkg::*;

	logic                   valid;
	logic                   ready;
	status_t                status;
	logic signed [PosW-1:0] position;
	logic signed [ErrW-1:0] tracking_error;
	logic                   feedback_update;
	logic                   wake;

	modport source (output valid, output status, output position, output tracking_error,
		output feedback_update, output wake, input ready);
	modport sink (input valid, input status, input position, input tracking_error,
		input feedback_update, input wake, output ready);
endinterface

// ----- rtl/sensor_frame_event_trigger.sv -----
// sensor frame deframer with angle, tracking error and event trigger
// depends on sfet_pkg, sfet_in_if, sfet_out_if
//
// channel   dir  fields
// din       in   rx_byte, setpoint, event_taken
// dout      out  status, position, tracking_error, feedback_update, wake
// cfg       in   cfg_wr_en, cfg_index, cfg_data (0 mid_raw, 1 event_threshold)
//
// one item per cycle sustained unless a result is stalled on dout; a taken byte passes through
// the input register, then frame check, multiply by constant and compare into result register
// the first three bytes after reset or after a good frame give no result
// arst_n clears window, fill count, pending event and valids; registers reset to defaults
// a stalled result holds dout; din keeps taking items while the input stage can drain
module sensor_frame_event_trigger (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  sfet_pkg::cfg_reg_t                 cfg_index,
	input  logic [sfet_pkg::CfgDataW-1:0]      cfg_data,
	sfet_in_if.sink                            din,
	sfet_out_if.source                         dout
);
	import sfet_pkg::*;

	// input stage
	logic                   v_s1;
	logic [ByteW-1:0]       byte_s1;
	logic signed [SetW-1:0] sp_s1;
	logic                   taken_s1;

	// state and configuration
	logic [ByteW-1:0] win_q [WinDepth];
	logic [FillW-1:0] fill_q;
	logic             pend_q;
	logic [MidW-1:0]  mid_q;
	logic [ThrW-1:0]  thr_q;

	// result register
	logic                   out_vld_q;
	status_t                st_q;
	logic signed [PosW-1:0] pos_q;
	logic signed [ErrW-1:0] err_q;
	logic                   fb_q;
	logic                   wk_q;

	logic                   full_c;
	logic                   pend_eff_c;
	logic [ByteW-1:0]       sum_c;
	logic [2*ByteW-1:0]     raw_c;
	logic signed [2*ByteW:0] diff_c;
	logic signed [PosW-1:0] pos_c;
	logic signed [ErrW-1:0] err_c;
	logic [ErrW-1:0]        mag_c;
	logic                   hit_c;
	status_t                st_c;
	logic                   fb_c;
	logic                   wk_c;
	logic                   out_free_c;
	logic                   adv_c;
	logic                   load_c;

	always_comb begin
		full_c     = (fill_q == FillW'(WinDepth));
		pend_eff_c = pend_q & ~taken_s1;
		sum_c      = win_q[1] + win_q[2];
		raw_c      = {win_q[1], win_q[2]};
		diff_c     = $signed({1'b0, raw_c}) - $signed({{(2*ByteW+1-MidW){1'b0}}, mid_q});
		pos_c      = PosW'(diff_c) * PosCoef;
		err_c      = ErrW'(sp_s1) - ErrW'(pos_c);
		mag_c      = err_c[ErrW-1] ? ErrW'(-err_c) : ErrW'(err_c);
		hit_c      = (mag_c >= {{(ErrW-ThrW){1'b0}}, thr_q});
		if (win_q[0] != StartByte) begin
			st_c = ST_BAD_START;
		end else if (sum_c != byte_s1) begin
			st_c = ST_BAD_SUM;
		end else begin
			st_c = ST_GOOD;
		end
		fb_c       = (st_c == ST_GOOD) & hit_c;
		wk_c       = fb_c & ~pend_eff_c;
		out_free_c = ~out_vld_q | dout.ready;
		adv_c      = v_s1 & (~full_c | out_free_c);
		load_c     = adv_c & full_c;
	end

	assign din.ready = ~v_s1 | adv_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (din.ready) begin
			v_s1 <= din.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (din.valid && din.ready) begin
			byte_s1  <= din.rx_byte;
			sp_s1    <= din.setpoint;
			taken_s1 <= din.event_taken;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mid_q <= MidW'(512);
			thr_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_MIDDLE: mid_q <= cfg_data[MidW-1:0];
				REG_THRESH: thr_q <= cfg_data[ThrW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q[0] <= '0;
			win_q[1] <= '0;
			win_q[2] <= '0;
			fill_q   <= '0;
			pend_q   <= 1'b0;
		end else if (adv_c) begin
			pend_q <= pend_eff_c | (full_c & wk_c);
			if (!full_c) begin
				win_q[fill_q] <= byte_s1;
				fill_q        <= fill_q + FillW'(1);
			end else if (st_c == ST_GOOD) begin
				win_q[0] <= '0;
				win_q[1] <= '0;
				win_q[2] <= '0;
				fill_q   <= '0;
			end else begin
				win_q[0] <= win_q[1];
				win_q[1] <= win_q[2];
				win_q[2] <= byte_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (load_c) begin
			out_vld_q <= 1'b1;
		end else if (dout.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_c) begin
			st_q <= st_c;
			fb_q <= fb_c;
			wk_q <= wk_c;
			if (st_c == ST_GOOD) begin
				pos_q <= pos_c;
				err_q <= err_c;
			end else begin
				pos_q <= '0;
				err_q <= '0;
			end
		end
	end

	assign dout.valid           = out_vld_q;
	assign dout.status          = st_q;
	assign dout.position        = pos_q;
	assign dout.tracking_error  = err_q;
	assign dout.feedback_update = fb_q;
	assign dout.wake            = wk_q;

	// a wake always leaves an event pending behind it
	a_wake_sets_pending: assert property (@(posedge clk) disable iff (!arst_n)
		load_c && wk_c |=> pend_q)
		else $error("event not pending after wake");

	// pending only rises through a wake
	a_pending_from_wake: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(pend_q) |-> $past(load_c && wk_c))
		else $error("event pending raised without wake");

	// a good frame empties the window
	a_good_empties: assert property (@(posedge clk) disable iff (!arst_n)
		load_c && st_c == ST_GOOD |=> fill_q == '0)
		else $error("window not emptied after good frame");

	// failed frames carry no angle and raise nothing
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && st_q != ST_GOOD |-> pos_q == '0 && err_q == '0 && !fb_q && !wk_q)
		else $error("failed frame with nonzero payload");

endmodule
